[src/c8x_pkg.sv]
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types, operation codes and helpers of the CHIP-8 execute unit.
// ----------------------------------------------------------------------------
package c8x_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;

	localparam logic [4:0] OP_RET   = 5'd0;
	localparam logic [4:0] OP_JP    = 5'd1;
	localparam logic [4:0] OP_CALL  = 5'd2;
	localparam logic [4:0] OP_SEQI  = 5'd3;
	localparam logic [4:0] OP_SNEI  = 5'd4;
	localparam logic [4:0] OP_SEQR  = 5'd5;
	localparam logic [4:0] OP_LDI   = 5'd6;
	localparam logic [4:0] OP_ADDI  = 5'd7;
	localparam logic [4:0] OP_LDR   = 5'd8;
	localparam logic [4:0] OP_OR    = 5'd9;
	localparam logic [4:0] OP_AND   = 5'd10;
	localparam logic [4:0] OP_XOR   = 5'd11;
	localparam logic [4:0] OP_ADD   = 5'd12;
	localparam logic [4:0] OP_SUB   = 5'd13;
	localparam logic [4:0] OP_SHR   = 5'd14;
	localparam logic [4:0] OP_SUBN  = 5'd15;
	localparam logic [4:0] OP_SHL   = 5'd16;
	localparam logic [4:0] OP_SNER  = 5'd17;
	localparam logic [4:0] OP_LDIX  = 5'd18;
	localparam logic [4:0] OP_JPOFF = 5'd19;
	localparam logic [4:0] OP_SKP   = 5'd20;
	localparam logic [4:0] OP_SKNP  = 5'd21;
	localparam logic [4:0] OP_LDDT  = 5'd22;
	localparam logic [4:0] OP_SETDT = 5'd23;
	localparam logic [4:0] OP_SETST = 5'd24;
	localparam logic [4:0] OP_ADDIX = 5'd25;
	localparam logic [4:0] OP_BCD   = 5'd26;
	localparam logic [4:0] OP_DUMP  = 5'd27;

	localparam logic [2:0] CFG_LOGIC_CLR = 3'd0;
	localparam logic [2:0] CFG_SHIFT_VY  = 3'd1;
	localparam logic [2:0] CFG_JP_V0     = 3'd2;
	localparam logic [2:0] CFG_DUMP_ADV  = 3'd3;
	localparam logic [2:0] CFG_START     = 3'd4;

	localparam logic [11:0] START_RESET = 12'd512;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVER  = 2'd1;
	localparam logic [1:0] ST_UNDER = 2'd2;

	localparam logic [1:0] TW_NONE  = 2'd0;
	localparam logic [1:0] TW_DELAY = 2'd1;
	localparam logic [1:0] TW_SOUND = 2'd2;

	localparam logic [3:0] FLAG_REG = 4'hf;

	typedef struct packed {
		logic        logic_clr;
		logic        shift_vy;
		logic        jp_v0;
		logic        dump_adv;
		logic [11:0] start;
		logic        start_load;
	} cfg_t;

	typedef struct packed {
		logic [4:0]  op;
		logic [3:0]  x;
		logic [3:0]  y;
		logic [11:0] addr;
		logic [15:0] keys;
		logic [7:0]  delay;
		logic        multi;
	} item_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [15:0] index_value;
		logic        mem_write;
		logic [15:0] mem_address;
		logic [7:0]  mem_data;
		logic [1:0]  timer_write;
		logic [7:0]  timer_value;
		logic [1:0]  status;
		logic        last;
	} res_t;

	// hundreds, tens, ones of a byte; tens by reciprocal 205/2048
	function automatic logic [11:0] bcd_digits(input logic [7:0] v);
		logic [1:0]  h;
		logic [7:0]  r;
		logic [14:0] p;
		logic [3:0]  t;
		logic [7:0]  o;
		h = (v >= 8'd200) ? 2'd2 : (v >= 8'd100) ? 2'd1 : 2'd0;
		r = v - 8'(h * 7'd100);
		p = 15'(r[6:0]) * 15'd205;
		t = p[14:11];
		o = r - 8'(t * 4'd10);
		return {2'b00, h, t, o[3:0]};
	endfunction

endpackage

[src/c8x_front.sv]
// ----------------------------------------------------------------------------
// c8x_front
// Input queue: accepts instruction beats, decodes operand fields, two deep.
// ----------------------------------------------------------------------------
module c8x_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [4:0]       operation,
	input  logic [15:0]      opcode,
	input  logic [15:0]      key_mask,
	input  logic [7:0]       delay_now,
	output logic             item_valid,
	output c8x_pkg::item_t   item,
	input  logic             item_take
);

	c8x_pkg::item_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;
	c8x_pkg::item_t dec;

	assign full       = (count_q == 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item       = ent_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_comb begin
		dec.op    = operation;
		dec.x     = opcode[11:8];
		dec.y     = opcode[7:4];
		dec.addr  = opcode[11:0];
		dec.keys  = key_mask;
		dec.delay = delay_now;
		dec.multi = (operation == c8x_pkg::OP_BCD) || (operation == c8x_pkg::OP_DUMP);
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

[src/c8x_back.sv]
// ----------------------------------------------------------------------------
// c8x_back
// Execution sequencer: register file, PC, I, return stack and result register.
// ----------------------------------------------------------------------------
module c8x_back #(
	parameter int unsigned STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  c8x_pkg::cfg_t    cfg,
	input  logic             item_valid,
	input  c8x_pkg::item_t   item,
	output logic             item_take,
	output logic             res_valid,
	output c8x_pkg::res_t    res,
	input  logic             res_pop
);

	localparam int unsigned SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EXEC  = 7'b0000010,
		S_FLAG  = 7'b0000100,
		S_EMIT  = 7'b0001000,
		S_BCD   = 7'b0010000,
		S_DREAD = 7'b0100000,
		S_DOUT  = 7'b1000000
	} state_t;

	state_t         state_q;
	c8x_pkg::item_t cur_q;
	logic [15:0]    pc_q;
	logic [15:0]    ix_q;
	logic [15:0]    base_q;
	logic [LW-1:0]  level_q;
	logic [3:0]     k_q;
	logic [1:0]     st_q;
	logic [1:0]     tw_q;
	logic [7:0]     tv_q;
	logic [11:0]    bcd_q;
	logic [7:0]     flag_val_q;

	logic [7:0]     rf [16];
	logic [15:0]    vld_q;
	logic [7:0]     rd_a_q;
	logic [7:0]     rd_b_q;
	logic [15:0]    stk [STACK_DEPTH];
	logic [15:0]    stk_rd_q;

	logic           rf_re;
	logic [3:0]     ra;
	logic [3:0]     rb;
	logic           rf_we;
	logic [3:0]     wa;
	logic [7:0]     wd;
	logic [LW-1:0]  lvl_m1;
	logic [SW-1:0]  stk_raddr;
	logic           stk_we;

	logic           out_free;
	logic           emit;
	c8x_pkg::res_t  emit_res;
	logic           out_valid_q;
	c8x_pkg::res_t  out_q;

	// execute-cycle results
	logic [7:0]     vx;
	logic [7:0]     vy;
	logic [15:0]    pc_inc;
	logic [15:0]    pc_n;
	logic [15:0]    ix_n;
	logic [LW-1:0]  level_n;
	logic           skip;
	logic           vx_we;
	logic [7:0]     vx_n;
	logic           fl_we;
	logic [7:0]     fl_n;
	logic [1:0]     st_n;
	logic [1:0]     tw_n;
	logic [8:0]     sum9;
	logic [7:0]     sh_src;
	logic           key;
	logic           err_under;
	logic           err_over;

	assign out_free  = !out_valid_q || res_pop;
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign item_take = (state_q == S_IDLE) && item_valid;

	assign lvl_m1    = level_q - LW'(1);
	assign stk_raddr = lvl_m1[SW-1:0];

	// register file read addresses
	always_comb begin
		rf_re = 1'b0;
		ra    = item.x;
		rb    = item.y;
		if (state_q == S_IDLE) begin
			rf_re = item_valid;
			if (item.op == c8x_pkg::OP_JPOFF && cfg.jp_v0) rb = 4'h0;
		end else if (state_q == S_DREAD) begin
			rf_re = 1'b1;
			ra    = k_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf[wa] <= wd;
		if (rf_re) begin
			rd_a_q <= vld_q[ra] ? rf[ra] : 8'h00;
			rd_b_q <= vld_q[rb] ? rf[rb] : 8'h00;
		end
		if (stk_we) stk[level_q[SW-1:0]] <= pc_inc;
		if (item_take) stk_rd_q <= stk[stk_raddr];
	end

	// execute
	always_comb begin
		logic is_logic;
		is_logic  = (cur_q.op == c8x_pkg::OP_OR) || (cur_q.op == c8x_pkg::OP_AND)
		         || (cur_q.op == c8x_pkg::OP_XOR);
		vx        = rd_a_q;
		vy        = rd_b_q;
		if (is_logic && cfg.logic_clr) begin
			if (cur_q.x == c8x_pkg::FLAG_REG) vx = 8'h00;
			if (cur_q.y == c8x_pkg::FLAG_REG) vy = 8'h00;
		end
		err_under = (cur_q.op == c8x_pkg::OP_RET) && (level_q == LW'(0));
		err_over  = (cur_q.op == c8x_pkg::OP_CALL) && (level_q >= LW'(STACK_DEPTH));
		pc_inc    = pc_q + 16'd2;
		pc_n      = pc_inc;
		ix_n      = ix_q;
		level_n   = level_q;
		skip      = 1'b0;
		vx_we     = 1'b0;
		vx_n      = 8'h00;
		fl_we     = 1'b0;
		fl_n      = 8'h00;
		st_n      = c8x_pkg::ST_OK;
		tw_n      = c8x_pkg::TW_NONE;
		sum9      = 9'd0;
		sh_src    = cfg.shift_vy ? vy : vx;
		key       = vx[7:4] == 4'h0 ? cur_q.keys[vx[3:0]] : 1'b0;
		stk_we    = 1'b0;
		case (cur_q.op)
			c8x_pkg::OP_RET: begin
				pc_n    = stk_rd_q;
				level_n = lvl_m1;
			end
			c8x_pkg::OP_JP: pc_n = {4'h0, cur_q.addr};
			c8x_pkg::OP_CALL: begin
				stk_we  = (state_q == S_EXEC) && !err_over;
				level_n = level_q + LW'(1);
				pc_n    = {4'h0, cur_q.addr};
			end
			c8x_pkg::OP_SEQI: skip = (vx == cur_q.addr[7:0]);
			c8x_pkg::OP_SNEI: skip = (vx != cur_q.addr[7:0]);
			c8x_pkg::OP_SEQR: skip = (vx == vy);
			c8x_pkg::OP_SNER: skip = (vx != vy);
			c8x_pkg::OP_LDI: begin vx_we = 1'b1; vx_n = cur_q.addr[7:0]; end
			c8x_pkg::OP_ADDI: begin vx_we = 1'b1; vx_n = vx + cur_q.addr[7:0]; end
			c8x_pkg::OP_LDR: begin vx_we = 1'b1; vx_n = vy; end
			c8x_pkg::OP_OR, c8x_pkg::OP_AND, c8x_pkg::OP_XOR: begin
				vx_we = 1'b1;
				vx_n  = (cur_q.op == c8x_pkg::OP_OR) ? (vx | vy)
				      : (cur_q.op == c8x_pkg::OP_AND) ? (vx & vy) : (vx ^ vy);
				fl_we = cfg.logic_clr && (cur_q.x != c8x_pkg::FLAG_REG);
			end
			c8x_pkg::OP_ADD: begin
				sum9  = {1'b0, vx} + {1'b0, vy};
				vx_we = 1'b1;
				vx_n  = sum9[7:0];
				fl_we = 1'b1;
				fl_n  = {7'h00, sum9[8]};
			end
			c8x_pkg::OP_SUB: begin
				vx_we = 1'b1;
				vx_n  = vx - vy;
				fl_we = 1'b1;
				fl_n  = {7'h00, vx >= vy};
			end
			c8x_pkg::OP_SUBN: begin
				vx_we = 1'b1;
				vx_n  = vy - vx;
				fl_we = 1'b1;
				fl_n  = {7'h00, vy >= vx};
			end
			c8x_pkg::OP_SHR: begin
				vx_we = 1'b1;
				vx_n  = {1'b0, sh_src[7:1]};
				fl_we = 1'b1;
				fl_n  = {7'h00, sh_src[0]};
			end
			c8x_pkg::OP_SHL: begin
				vx_we = 1'b1;
				vx_n  = {sh_src[6:0], 1'b0};
				fl_we = 1'b1;
				fl_n  = {7'h00, sh_src[7]};
			end
			c8x_pkg::OP_LDIX: ix_n = {4'h0, cur_q.addr};
			// port b holds V0 when the quirk is on, else offset comes from vx
			c8x_pkg::OP_JPOFF: pc_n = {4'h0, cur_q.addr} + {8'h00, cfg.jp_v0 ? vy : vx};
			c8x_pkg::OP_SKP: skip = key;
			c8x_pkg::OP_SKNP: skip = !key;
			c8x_pkg::OP_LDDT: begin vx_we = 1'b1; vx_n = cur_q.delay; end
			c8x_pkg::OP_SETDT: tw_n = c8x_pkg::TW_DELAY;
			c8x_pkg::OP_SETST: tw_n = c8x_pkg::TW_SOUND;
			c8x_pkg::OP_ADDIX: ix_n = ix_q + {8'h00, vx};
			c8x_pkg::OP_DUMP: begin
				if (cfg.dump_adv) ix_n = ix_q + {12'h000, cur_q.x} + 16'd1;
			end
			default: ;
		endcase
		if (skip) pc_n = pc_inc + 16'd2;
		// failed call or return leaves everything as it was
		if (err_under || err_over) begin
			pc_n    = pc_q;
			ix_n    = ix_q;
			level_n = level_q;
			vx_we   = 1'b0;
			fl_we   = 1'b0;
			st_n    = err_under ? c8x_pkg::ST_UNDER : c8x_pkg::ST_OVER;
		end
	end

	// register file write port: vx in execute, flag in the following S_FLAG state
	always_comb begin
		rf_we = 1'b0;
		wa    = cur_q.x;
		wd    = vx_n;
		if (state_q == S_EXEC) begin
			rf_we = vx_we;
		end else if (state_q == S_FLAG) begin
			rf_we = 1'b1;
			wa    = c8x_pkg::FLAG_REG;
			wd    = flag_val_q;
		end
	end

	// result beat
	always_comb begin
		emit_res.next_pc     = pc_q;
		emit_res.index_value = ix_q;
		emit_res.mem_write   = 1'b0;
		emit_res.mem_address = 16'h0000;
		emit_res.mem_data    = 8'h00;
		emit_res.timer_write = tw_q;
		emit_res.timer_value = tv_q;
		emit_res.status      = st_q;
		emit_res.last        = 1'b1;
		emit = 1'b0;
		case (state_q)
			S_EMIT: emit = out_free;
			S_BCD: begin
				emit                 = out_free;
				emit_res.mem_write   = 1'b1;
				emit_res.mem_address = base_q + {12'h000, k_q};
				emit_res.mem_data    = (k_q == 4'd0) ? {4'h0, bcd_q[11:8]}
				                     : (k_q == 4'd1) ? {4'h0, bcd_q[7:4]}
				                     : {4'h0, bcd_q[3:0]};
				emit_res.last        = (k_q == 4'd2);
			end
			S_DOUT: begin
				emit                 = out_free;
				emit_res.mem_write   = 1'b1;
				emit_res.mem_address = base_q + {12'h000, k_q};
				emit_res.mem_data    = rd_a_q;
				emit_res.last        = (k_q == cur_q.x);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (item_take) cur_q <= item;
		if (emit) out_q <= emit_res;
		if (state_q == S_EXEC) begin
			st_q       <= st_n;
			tw_q       <= tw_n;
			tv_q       <= (tw_n == c8x_pkg::TW_NONE) ? 8'h00 : vx;
			bcd_q      <= c8x_pkg::bcd_digits(vx);
			base_q     <= ix_q;
			flag_val_q <= fl_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= {4'h0, c8x_pkg::START_RESET};
			ix_q        <= 16'h0000;
			level_q     <= '0;
			k_q         <= 4'd0;
			vld_q       <= 16'h0000;
			out_valid_q <= 1'b0;
		end else begin
			if (rf_we) vld_q[wa] <= 1'b1;
			if (emit) out_valid_q <= 1'b1;
			else if (res_pop) out_valid_q <= 1'b0;
			if (cfg.start_load) pc_q <= {4'h0, cfg.start};
			case (state_q)
				S_IDLE: begin
					if (item_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					pc_q      <= pc_n;
					ix_q      <= ix_n;
					level_q   <= level_n;
					k_q       <= 4'd0;
					if (err_under || err_over) state_q <= S_EMIT;
					else if (cur_q.op == c8x_pkg::OP_BCD) state_q <= S_BCD;
					else if (cur_q.op == c8x_pkg::OP_DUMP) state_q <= S_DREAD;
					else if (fl_we) state_q <= S_FLAG;
					else state_q <= S_EMIT;
				end
				S_FLAG: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) state_q <= S_IDLE;
				end
				S_BCD: begin
					if (out_free) begin
						k_q <= k_q + 4'd1;
						if (k_q == 4'd2) state_q <= S_IDLE;
					end
				end
				S_DREAD: state_q <= S_DOUT;
				S_DOUT: begin
					if (out_free) begin
						if (k_q == cur_q.x) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 4'd1;
							state_q <= S_DREAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/chip8_register_alu_execute_unit.sv]
// Each accepted beat passes issue with register file read, execute, optional
// flag write and result load; the next beat is taken only back in idle.
// BCD gives one result a cycle while the result register is free; dump
// alternates a register file read and a result (one read port per result).
// Reset: V0..VF read as zero through valid bits, PC = 512, I = 0, stack empty;
// return stack contents undefined until pushed.
// ----------------------------------------------------------------------------
// chip8_register_alu_execute_unit
// CHIP-8 instruction execute unit with input queue and result register.
// ----------------------------------------------------------------------------
module chip8_register_alu_execute_unit #(
	parameter int unsigned STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [4:0]  operation,
	input  logic [15:0] opcode,
	input  logic [15:0] key_mask,
	input  logic [7:0]  delay_now,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] next_pc,
	output logic [15:0] index_value,
	output logic        mem_write,
	output logic [15:0] mem_address,
	output logic [7:0]  mem_data,
	output logic [1:0]  timer_write,
	output logic [7:0]  timer_value,
	output logic [1:0]  status,
	output logic        last,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	c8x_pkg::cfg_t  cfg;
	logic           logic_clr_q;
	logic           shift_vy_q;
	logic           jp_v0_q;
	logic           dump_adv_q;
	logic           item_valid;
	c8x_pkg::item_t item;
	logic           item_take;
	logic           res_valid;
	c8x_pkg::res_t  res;

	// start address goes straight into the PC, nothing else keeps it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logic_clr_q <= 1'b1;
			shift_vy_q  <= 1'b0;
			jp_v0_q     <= 1'b1;
			dump_adv_q  <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				c8x_pkg::CFG_LOGIC_CLR: logic_clr_q <= cfg_data[0];
				c8x_pkg::CFG_SHIFT_VY:  shift_vy_q  <= cfg_data[0];
				c8x_pkg::CFG_JP_V0:     jp_v0_q     <= cfg_data[0];
				c8x_pkg::CFG_DUMP_ADV:  dump_adv_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.logic_clr  = logic_clr_q;
		cfg.shift_vy   = shift_vy_q;
		cfg.jp_v0      = jp_v0_q;
		cfg.dump_adv   = dump_adv_q;
		cfg.start      = cfg_data;
		cfg.start_load = cfg_write && (cfg_index == c8x_pkg::CFG_START);
	end

	c8x_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (operation),
		.opcode     (opcode),
		.key_mask   (key_mask),
		.delay_now  (delay_now),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	c8x_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_valid  (res_valid),
		.res        (res),
		.res_pop    (pop)
	);

	assign empty       = !res_valid;
	assign next_pc     = res.next_pc;
	assign index_value = res.index_value;
	assign mem_write   = res.mem_write;
	assign mem_address = res.mem_address;
	assign mem_data    = res.mem_data;
	assign timer_write = res.timer_write;
	assign timer_value = res.timer_value;
	assign status      = res.status;
	assign last        = res.last;

`ifndef SYNTH
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != c8x_pkg::ST_OK) |-> (last && !mem_write))
		else $error("stack error beat is not a single result");
	a_mem_no_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && mem_write) |-> (timer_write == c8x_pkg::TW_NONE))
		else $error("memory write beat carries a timer load");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status != 2'd3 && timer_write != 2'd3))
		else $error("undefined status or timer code");
`endif

endmodule
